[src/sist_pkg.sv]
package sist_pkg;

  localparam int DATA_W      = 32;
  localparam int KIND_W      = 2;
  localparam int COUNT_OUT_W = 7;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DECIDE,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_DONE
  } sist_state_t;

  typedef struct packed {
    logic              we;
    logic [DATA_W-1:0] wdata;
  } sist_wr_t;

endpackage

[src/sist_ram.sv]
module sist_ram import sist_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  sist_wr_t          wr,
  input  logic [AW-1:0]     waddr,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/sorted_integer_set_table.sv]
// Sorted set of distinct signed 32-bit values, at most CAPACITY of them.
// Input channel (in_valid/in_ready): one beat carries an operation in_kind
// (insert, delete, query; the unused code acts as a query) and in_value.
// Result channel (out_valid/out_ready): exactly one beat per input beat, in
// order: was_present before the operation, element count afterwards (low
// 7 bits), and dropped_full for a new value refused by a full table.
// One item at a time: in_ready is high only while the sequencer is idle.
// Each scan and move step is a read then a compare/write, as the entry
// memory has one read and one write port with registered read data; an
// item's work grows with the entries scanned below the value's place and
// the entries moved by an insert or delete.
// The result sits in an output register, so a new beat is taken while the
// previous result waits; if the receiver stalls, the next item finishes its
// work and then holds until the waiting result is taken.
// Reset clears the count and the handshake state only; entry memory contents
// are never used beyond the count, so it needs no clearing.
module sorted_integer_set_table import sist_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_was_present,
  output logic [COUNT_OUT_W-1:0] out_element_count,
  output logic                   out_dropped_full
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  sist_state_t state_r, state_nxt;

  logic [KIND_W-1:0]        kind_r, kind_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  logic                     present_r, present_nxt;
  logic                     dropped_r, dropped_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_was_present_r, out_was_present_nxt;
  logic [COUNT_OUT_W-1:0]   out_element_count_r, out_element_count_nxt;
  logic                     out_dropped_full_r, out_dropped_full_nxt;

  sist_wr_t                 ram_wr;
  logic [AW-1:0]            ram_waddr;
  logic [AW-1:0]            ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_val;
  logic                     rd_lt, rd_eq;
  logic                     in_beat, out_free;
  logic [CW-1:0]            idx_inc, idx_dec;

  sist_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .waddr (ram_waddr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared compare unit
  assign rd_val  = ram_rdata;
  assign rd_lt   = rd_val < value_r;
  assign rd_eq   = rd_val == value_r;
  assign idx_inc = idx_r + 1'b1;
  assign idx_dec = idx_r - 1'b1;

  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_beat) state_nxt = ST_SRCH_RD;
      ST_SRCH_RD:  state_nxt = (idx_r >= cnt_r) ? ST_DECIDE : ST_SRCH_CMP;
      ST_SRCH_CMP: state_nxt = rd_lt ? ST_SRCH_RD : ST_DECIDE;
      ST_DECIDE: begin
        state_nxt = ST_DONE;
        if (kind_r == KIND_INSERT && !present_r && cnt_r < CAP_C) begin
          state_nxt = ST_INS_RD;
        end else if (kind_r == KIND_DELETE && present_r) begin
          state_nxt = ST_DEL_RD;
        end
      end
      ST_INS_RD:   state_nxt = (idx_r == pos_r) ? ST_DONE : ST_INS_WR;
      ST_INS_WR:   state_nxt = ST_INS_RD;
      ST_DEL_RD:   state_nxt = (idx_inc >= cnt_r) ? ST_DONE : ST_DEL_WR;
      ST_DEL_WR:   state_nxt = ST_DEL_RD;
      ST_DONE:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    ram_wr.we    = 1'b0;
    ram_wr.wdata = ram_rdata;
    ram_waddr    = idx_r[AW-1:0];
    ram_raddr    = idx_r[AW-1:0];
    unique case (state_r)
      ST_INS_RD: begin
        ram_raddr = idx_dec[AW-1:0];
        if (idx_r == pos_r) begin
          ram_wr.we    = 1'b1;
          ram_wr.wdata = value_r;
        end
      end
      ST_INS_WR: ram_wr.we  = 1'b1;
      ST_DEL_RD: ram_raddr  = idx_inc[AW-1:0];
      ST_DEL_WR: ram_wr.we  = 1'b1;
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    kind_nxt              = kind_r;
    value_nxt             = value_r;
    cnt_nxt               = cnt_r;
    idx_nxt               = idx_r;
    pos_nxt               = pos_r;
    present_nxt           = present_r;
    dropped_nxt           = dropped_r;
    out_valid_nxt         = out_valid_r && !out_ready;
    out_was_present_nxt   = out_was_present_r;
    out_element_count_nxt = out_element_count_r;
    out_dropped_full_nxt  = out_dropped_full_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          kind_nxt    = in_kind;
          value_nxt   = in_value;
          idx_nxt     = '0;
          present_nxt = 1'b0;
          dropped_nxt = 1'b0;
        end
      end
      ST_SRCH_RD: begin
        if (idx_r >= cnt_r) begin
          pos_nxt = idx_r;
        end
      end
      ST_SRCH_CMP: begin
        if (rd_lt) begin
          idx_nxt = idx_inc;
        end else begin
          pos_nxt     = idx_r;
          present_nxt = rd_eq;
        end
      end
      ST_DECIDE: begin
        if (kind_r == KIND_INSERT && !present_r) begin
          if (cnt_r >= CAP_C) begin
            dropped_nxt = 1'b1;
          end else begin
            idx_nxt = cnt_r;
          end
        end else if (kind_r == KIND_DELETE && present_r) begin
          idx_nxt = pos_r;
        end
      end
      ST_INS_RD: begin
        if (idx_r == pos_r) cnt_nxt = cnt_r + 1'b1;
      end
      ST_INS_WR: idx_nxt = idx_dec;
      ST_DEL_RD: begin
        if (idx_inc >= cnt_r) cnt_nxt = cnt_r - 1'b1;
      end
      ST_DEL_WR: idx_nxt = idx_inc;
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_was_present_nxt   = present_r;
          out_element_count_nxt = COUNT_OUT_W'(cnt_r);
          out_dropped_full_nxt  = dropped_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r              <= kind_nxt;
    value_r             <= value_nxt;
    idx_r               <= idx_nxt;
    pos_r               <= pos_nxt;
    present_r           <= present_nxt;
    dropped_r           <= dropped_nxt;
    out_was_present_r   <= out_was_present_nxt;
    out_element_count_r <= out_element_count_nxt;
    out_dropped_full_r  <= out_dropped_full_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_was_present   = out_was_present_r;
  assign out_element_count = out_element_count_r;
  assign out_dropped_full  = out_dropped_full_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C)
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + 1'b1) ||
                     (cnt_r + 1'b1 == $past(cnt_r)))
    else $error("entry count moved by more than one");

  a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dropped_full_r |-> !out_was_present_r)
    else $error("drop flagged for a value already present");

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr.we |-> (state_r == ST_INS_RD) || (state_r == ST_INS_WR) ||
                  (state_r == ST_DEL_WR))
    else $error("memory write outside a shift step");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && !out_free |=> (state_r == ST_DONE))
    else $error("result overwritten while receiver stalled");

endmodule

[sim/sorted_integer_set_table_tb.sv]
`timescale 1ns / 100ps
module sorted_integer_set_table_tb import sist_pkg::*;;

  localparam int CAPACITY        = 64;
  localparam int MAX_ITEM_CYCLES = 4 * CAPACITY + 16;
  localparam int RANDOM_OPS      = 1600;
  localparam int PHASE_LEN       = 200;
  localparam int POOL_SIZE       = 96;
  localparam int REPORT_LIMIT    = 10;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                   was_present;
    logic [COUNT_OUT_W-1:0] element_count;
    logic                   dropped_full;
  } set_result_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic                     typed;
    set_result_t              exp;
  } dir_row_t;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [KIND_W-1:0]        in_kind = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_was_present;
  logic [COUNT_OUT_W-1:0]   out_element_count;
  logic                     out_dropped_full;

  // predictor state: ascending entries, valid below held_count
  logic signed [DATA_W-1:0] held [CAPACITY];
  int                       held_count = 0;
  logic signed [DATA_W-1:0] value_pool [POOL_SIZE];

  set_result_t pending_results [$];
  int          mismatch_count = 0;
  bit          no_idle = 1'b0;

  localparam int DIR_ROWS = 24;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{KIND_QUERY,  32'sd0,         1'b1, '{1'b0, 7'd0, 1'b0}},
    '{KIND_DELETE, 32'sd0,         1'b1, '{1'b0, 7'd0, 1'b0}},
    '{KIND_INSERT, VAL_MIN,        1'b1, '{1'b0, 7'd1, 1'b0}},
    '{KIND_INSERT, VAL_MAX,        1'b1, '{1'b0, 7'd2, 1'b0}},
    '{KIND_INSERT, 32'sd0,         1'b1, '{1'b0, 7'd3, 1'b0}},
    '{KIND_INSERT, VAL_MAX,        1'b1, '{1'b1, 7'd3, 1'b0}},
    '{KIND_QUERY,  VAL_MIN,        1'b1, '{1'b1, 7'd3, 1'b0}},
    '{KIND_QUERY,  VAL_MAX,        1'b1, '{1'b1, 7'd3, 1'b0}},
    '{KIND_UNUSED, VAL_MAX,        1'b1, '{1'b1, 7'd3, 1'b0}},
    '{KIND_UNUSED, 32'sd5,         1'b1, '{1'b0, 7'd3, 1'b0}},
    '{KIND_QUERY,  -32'sd1,        1'b1, '{1'b0, 7'd3, 1'b0}},
    '{KIND_INSERT, -32'sd1,        1'b0, '0},
    '{KIND_INSERT, 32'sd1,         1'b0, '0},
    '{KIND_INSERT, 32'sh7FFF_FFFE, 1'b0, '0},
    '{KIND_INSERT, 32'sh8000_0001, 1'b0, '0},
    '{KIND_DELETE, 32'sd5,         1'b1, '{1'b0, 7'd7, 1'b0}},
    '{KIND_DELETE, VAL_MIN,        1'b0, '0},
    '{KIND_DELETE, VAL_MIN,        1'b0, '0},
    '{KIND_DELETE, VAL_MAX,        1'b0, '0},
    '{KIND_QUERY,  32'sh7FFF_FFFE, 1'b0, '0},
    '{KIND_INSERT, 32'sh5555_5555, 1'b0, '0},
    '{KIND_INSERT, 32'shAAAA_AAAA, 1'b0, '0},
    '{KIND_DELETE, 32'sd0,         1'b0, '0},
    '{KIND_QUERY,  32'shAAAA_AAAA, 1'b0, '0}
  };

  sorted_integer_set_table #(.CAPACITY(CAPACITY)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_was_present   (out_was_present),
    .out_element_count (out_element_count),
    .out_dropped_full  (out_dropped_full)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("[sorted_integer_set_table] ERROR");
    $finish;
  end

  // Applies one operation to the predicted set and returns its result.
  function automatic set_result_t apply_op(input logic [KIND_W-1:0] k,
                                           input logic signed [DATA_W-1:0] v);
    set_result_t r;
    int pos;
    logic present;
    r = '0;
    pos = 0;
    while (pos < held_count && held[pos] < v) pos++;
    present = (pos < held_count) && (held[pos] == v);
    case (k)
      KIND_INSERT: begin
        if (!present) begin
          if (held_count >= CAPACITY) begin
            r.dropped_full = 1'b1;
          end else begin
            for (int i = held_count; i > pos; i--) held[i] = held[i-1];
            held[pos] = v;
            held_count++;
          end
        end
      end
      KIND_DELETE: begin
        if (present) begin
          for (int i = pos; i + 1 < held_count; i++) held[i] = held[i+1];
          held_count--;
        end
      end
      default: ;  // query and the unused code leave the set alone
    endcase
    r.was_present   = present;
    r.element_count = held_count[COUNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(input op_mix_t mix);
    int r;
    int ins_pct;
    int del_pct;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:     begin ins_pct = 70; del_pct = 10; end
      MIX_BALANCED: begin ins_pct = 40; del_pct = 35; end
      default:      begin ins_pct = 15; del_pct = 60; end
    endcase
    if (r < ins_pct) return KIND_INSERT;
    if (r < ins_pct + del_pct) return KIND_DELETE;
    if (r < 95) return KIND_QUERY;
    return KIND_UNUSED;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    logic signed [DATA_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      v = $urandom;
    end else if (r < 18) begin
      case ($urandom_range(0, 5))
        0: v = VAL_MIN;
        1: v = VAL_MIN + 1;
        2: v = VAL_MAX;
        3: v = VAL_MAX - 1;
        4: v = -32'sd1;
        default: v = 32'sd0;
      endcase
    end else if (r < 55 && held_count > 0) begin
      v = held[$urandom_range(0, held_count - 1)];
      // neighbors of a present entry probe the ordering compare
      if (r >= 45) v = (r & 1) ? v + 1 : v - 1;
    end else begin
      v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return v;
  endfunction

  task automatic issue_op(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v,
                          input logic typed, input set_result_t typed_exp);
    set_result_t predicted;
    if (!no_idle && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= k;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_op(k, v);
    pending_results.push_back(typed ? typed_exp : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    set_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected result beat: present=%0b count=%0d dropped=%0b",
                   $realtime, out_was_present, out_element_count, out_dropped_full);
      end else begin
        want = pending_results.pop_front();
        if (out_was_present !== want.was_present ||
            out_element_count !== want.element_count ||
            out_dropped_full !== want.dropped_full) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"%0t: result mismatch: exp present=%0b count=%0d dropped=%0b",
                      " got present=%0b count=%0d dropped=%0b"}, $realtime,
                     want.was_present, want.element_count, want.dropped_full,
                     out_was_present, out_element_count, out_dropped_full);
        end
      end
    end
    out_ready <= no_idle || ($urandom_range(0, 99) >= 18);
  end

  initial begin
    op_mix_t mix;
    for (int i = 0; i < POOL_SIZE; i++)
      value_pool[i] = (i < POOL_SIZE / 2) ? $urandom : 32'(i * 7 - 300);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      issue_op(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].exp);
    wait_drained();

    // phases cycle fill / balanced / drain so the table runs full and empty;
    // the third phase runs with no idling on either side
    for (int p = 0; p < RANDOM_OPS / PHASE_LEN; p++) begin
      no_idle = (p == 2);
      case (p % 3)
        0: mix = MIX_FILL;
        1: mix = MIX_BALANCED;
        default: mix = MIX_DRAIN;
      endcase
      for (int i = 0; i < PHASE_LEN; i++)
        issue_op(pick_kind(mix), pick_value(), 1'b0, '0);
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (MAX_ITEM_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("[sorted_integer_set_table] OK");
    else
      $display("[sorted_integer_set_table] ERROR");
    $finish;
  end

endmodule
